@@ hw/rtl/rad_pkg.sv @@
// ----------------------------------------------------------------------------
// rad_pkg: shared types and constants of the region address decoder
// Region entry, request token that walks the cell chain, commit bus,
// request kind and status codes.
// ----------------------------------------------------------------------------
package rad_pkg;

  localparam int MAX_REGIONS = 16;
  localparam int ADDR_BITS   = 16;
  localparam int DATA_BITS   = 8;
  localparam int SLOT_W      = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int LEN_W       = 17;
  localparam int END_W       = ((ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W) + 1;

  localparam logic [END_W-1:0] SPACE_END = END_W'(1) << ADDR_BITS;

  typedef enum logic [3:0] {
    KIND_ADD_RD  = 4'd0,
    KIND_ADD_WR  = 4'd1,
    KIND_RM_OWN  = 4'd2,
    KIND_RM_BASE = 4'd3,
    KIND_CLEAR   = 4'd4,
    KIND_READ    = 4'd5,
    KIND_POKE    = 4'd6,
    KIND_WRITE   = 4'd7,
    KIND_RD_DATA = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_OPEN    = 2'd1,
    STAT_OVERLAP = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] base;
    logic [LEN_W-1:0]     length;
    logic [3:0]           owner;
  } entry_t;

  typedef struct packed {
    logic                 valid;
    logic [3:0]           kind;
    logic [ADDR_BITS-1:0] addr;
    logic [LEN_W-1:0]     length;
    logic [3:0]           owner;
    logic [DATA_BITS-1:0] value;
    logic [END_W-1:0]     new_end;
    logic                 overlap;
    logic                 free_found;
    logic [SLOT_W-1:0]    free_slot;
    logic                 hit_found;
    logic [SLOT_W-1:0]    hit_slot;
    logic [3:0]           hit_owner;
    logic [15:0]          hit_offset;
  } token_t;

  typedef struct packed {
    logic              en;
    logic              wr_tab;
    logic [SLOT_W-1:0] slot;
    entry_t            entry;
  } commit_t;

  function automatic logic [END_W-1:0] region_end(input logic [ADDR_BITS-1:0] base,
                                                  input logic [LEN_W-1:0] len);
    logic [END_W-1:0] e;
    e = END_W'(base) + END_W'(len);
    return (e > SPACE_END) ? SPACE_END : e;
  endfunction

endpackage

@@ hw/rtl/rad_cell.sv @@
// ----------------------------------------------------------------------------
// rad_cell: one slot of the read and write region tables
// Checks the passing request against its two entries, folds its findings
// into the token and hands the token to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module rad_cell
  import rad_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [SLOT_W-1:0] cell_idx,
  input  logic [15:0]       owner_mask,
  input  token_t            tok_in,
  input  commit_t           commit,
  output token_t            tok_out
);

  entry_t           rd;
  entry_t           wr;
  entry_t           rd_next;
  entry_t           wr_next;
  entry_t           sel;
  token_t           tok_next;
  logic [END_W-1:0] sel_end;
  logic             overlap_here;
  logic             hit_here;

  always_comb begin
    sel = rd;
    if (tok_in.kind == KIND_ADD_WR || tok_in.kind == KIND_WRITE) begin
      sel = wr;
    end
    sel_end = region_end(sel.base, sel.length);
    overlap_here = sel.valid && (tok_in.length != '0) && (sel.length != '0) &&
                   (END_W'(tok_in.addr) < sel_end) && (END_W'(sel.base) < tok_in.new_end);
    hit_here = sel.valid && owner_mask[sel.owner] && (sel.base <= tok_in.addr) &&
               (END_W'(tok_in.addr) < sel_end);
  end

  always_comb begin
    tok_next = tok_in;
    rd_next  = rd;
    wr_next  = wr;
    if (tok_in.valid) begin
      case (tok_in.kind)
        KIND_ADD_RD, KIND_ADD_WR: begin
          if (overlap_here) begin
            tok_next.overlap = 1'b1;
          end
          if (!sel.valid && !tok_in.free_found) begin
            tok_next.free_found = 1'b1;
            tok_next.free_slot  = cell_idx;
          end
        end
        KIND_READ, KIND_POKE, KIND_WRITE: begin
          // lowest slot wins
          if (hit_here && !tok_in.hit_found) begin
            tok_next.hit_found  = 1'b1;
            tok_next.hit_slot   = cell_idx;
            tok_next.hit_owner  = sel.owner;
            tok_next.hit_offset = 16'(tok_in.addr - sel.base);
          end
        end
        KIND_RM_OWN: begin
          if (rd.owner == tok_in.owner) rd_next.valid = 1'b0;
          if (wr.owner == tok_in.owner) wr_next.valid = 1'b0;
        end
        KIND_RM_BASE: begin
          if (rd.base == tok_in.addr) rd_next.valid = 1'b0;
          if (wr.base == tok_in.addr) wr_next.valid = 1'b0;
        end
        KIND_CLEAR: begin
          rd_next.valid = 1'b0;
          wr_next.valid = 1'b0;
        end
        default: begin
        end
      endcase
    end
    if (commit.en && commit.slot == cell_idx) begin
      if (commit.wr_tab) begin
        wr_next = commit.entry;
      end else begin
        rd_next = commit.entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd      <= rd_next;
    wr      <= wr_next;
    tok_out <= tok_next;
    if (rst) begin
      rd.valid      <= 1'b0;
      wr.valid      <= 1'b0;
      tok_out.valid <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/region_address_decoder_open_bus.sv @@
// ----------------------------------------------------------------------------
// region_address_decoder_open_bus: region decoder with open-bus latch
// Read and write region tables held in a row of slot cells.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: tuser carries the kind (add read region,
// add write region, remove by owner, remove by base, clear, read, poke,
// write, read data), tdata the address, length, owner and value. Every
// request gives exactly one result on the m_ stream: status, slot, owner,
// offset and the open-bus latch value after the request.
// A request walks the chain of MAX_REGIONS cells, one cell per cycle, each
// cell checking its slot of both tables; an add is then written into the
// lowest free slot found. One request is in flight at a time; it passes
// the head register, the register of each cell and the finish register
// before its result is loaded into the output register. The next request
// is taken once the result is in the output register, even while it waits there.
// When the receiver stalls, the finished request holds before its commit
// until the output register is free.
// cfg_we writes the owner-valid mask; write it only while idle.
// Reset empties both tables, clears the latch and sets the mask to all ones.
// ----------------------------------------------------------------------------
module region_address_decoder_open_bus
  import rad_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // addr[15:0], length[32:16], owner[36:33], value[44:37]
  input  logic [3:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // status[1:0], slot[5:2], owner_id[9:6],
                                 // offset[25:10], bus_value[33:26]
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  state_t               state;
  state_t               state_next;
  token_t               tok [MAX_REGIONS+1];
  token_t               tok_head;
  token_t               launch;
  token_t               fin;
  commit_t              commit;
  logic [15:0]          owner_mask;
  logic [DATA_BITS-1:0] latch;
  logic [DATA_BITS-1:0] latch_next;
  logic                 out_load;
  logic                 fin_load;
  logic [1:0]           r_status;
  logic [3:0]           r_slot;
  logic [3:0]           r_owner;
  logic [15:0]          r_offset;

  assign tok[0] = tok_head;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_REGIONS; gi++) begin : g_cell
      rad_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .cell_idx   (SLOT_W'(gi)),
        .owner_mask (owner_mask),
        .tok_in     (tok[gi]),
        .commit     (commit),
        .tok_out    (tok[gi+1])
      );
    end
  endgenerate

  always_comb begin
    launch            = '0;
    launch.valid      = s_tvalid && s_tready;
    launch.kind       = s_tuser;
    launch.addr       = ADDR_BITS'(s_tdata[15:0]);
    launch.length     = s_tdata[32:16];
    launch.owner      = s_tdata[36:33];
    launch.value      = DATA_BITS'(s_tdata[44:37]);
    launch.new_end    = region_end(launch.addr, launch.length);
  end

  // next state, handshake and commit
  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    fin_load     = 1'b0;
    out_load     = 1'b0;
    commit       = '0;
    commit.wr_tab       = (fin.kind == KIND_ADD_WR);
    commit.slot         = fin.free_slot;
    commit.entry.valid  = 1'b1;
    commit.entry.base   = fin.addr;
    commit.entry.length = fin.length;
    commit.entry.owner  = fin.owner;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (tok[MAX_REGIONS].valid) begin
          fin_load   = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          commit.en  = (fin.kind == KIND_ADD_RD || fin.kind == KIND_ADD_WR) &&
                       !fin.overlap && fin.free_found;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // result fields of the finished request
  always_comb begin
    r_status   = STAT_OK;
    r_slot     = '0;
    r_owner    = '0;
    r_offset   = '0;
    latch_next = latch;
    case (fin.kind)
      KIND_ADD_RD, KIND_ADD_WR: begin
        if (fin.overlap) begin
          r_status = STAT_OVERLAP;
        end else if (!fin.free_found) begin
          r_status = STAT_FULL;
        end else begin
          r_slot  = 4'(fin.free_slot);
          r_owner = fin.owner;
        end
      end
      KIND_READ, KIND_POKE, KIND_WRITE: begin
        if (fin.hit_found) begin
          r_slot   = 4'(fin.hit_slot);
          r_owner  = fin.hit_owner;
          r_offset = fin.hit_offset;
        end else begin
          r_status = STAT_OPEN;
        end
        if (fin.kind == KIND_WRITE) latch_next = fin.value;
      end
      KIND_RD_DATA: latch_next = fin.value;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    tok_head <= launch;
    if (fin_load) fin <= tok[MAX_REGIONS];
    if (out_load) begin
      m_tdata <= {6'd0, 8'(latch_next), r_offset, r_owner, r_slot, r_status};
    end
    if (rst) begin
      state          <= ST_IDLE;
      tok_head.valid <= 1'b0;
      m_tvalid       <= 1'b0;
      latch          <= '0;
      owner_mask     <= 16'hFFFF;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
        latch    <= latch_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) owner_mask <= cfg_wdata;
    end
  end

endmodule
